// ----- src/ght_pkg.sv -----
// Shared types and fixed field widths for the generational handle table.
// No dependencies; imported by every module of the block.
package ght_pkg;

   // Port field widths fixed by the item format
   localparam int SLOT_IN_W  = 10;
   localparam int PORT_GEN_W = 32;
   localparam int KIND_W     = 3;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CHECK  = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Free stack update strobes, issued in the execute cycle
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

endpackage

// ----- src/ght_free_stack.sv -----
// LIFO free-slot stack: synchronous memory with a depth counter.
// Depends on ght_pkg for the control struct.
module ght_free_stack
   import ght_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 42
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  stack_ctrl_type               ctrl,
   input  logic [DATA_W-1:0]            push_data,
   output logic [DATA_W-1:0]            top_data,
   output logic [$clog2(DEPTH+1)-1:0]   depth
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [DATA_W-1:0] top_data_ff;
   logic [CNT_W-1:0]  top_idx;

   assign top_idx = depth_ff - CNT_W'(1);

   // depth counter
   always_comb begin
      depth_in = depth_ff;
      if (ctrl.push) begin
         depth_in = depth_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         depth_in = depth_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // memory: push writes at the depth, read fetches the top item
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[depth_ff[ADDR_W-1:0]] <= push_data;
      end
      if (rd_en) begin
         top_data_ff <= mem[top_idx[ADDR_W-1:0]];
      end
   end

   assign top_data = top_data_ff;
   assign depth    = depth_ff;

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> depth_ff != '0)
      else $error("free stack popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> depth_ff < CNT_W'(DEPTH))
      else $error("free stack pushed while full");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && ctrl.pop))
      else $error("free stack push and pop in one cycle");

endmodule

// ----- src/generational_handle_table.sv -----
// Generational handle table top level: slot store, high-water mark and live count.
// Depends on ght_pkg and ght_free_stack.
//
// Each item has an accept cycle and an execute state: the accept cycle registers the
// item and reads the slot entry and the top of the free stack from synchronous memory,
// and the execute state, held while an untaken result fills the result register,
// decides the outcome, writes both memories and loads the result register. A new item
// is taken once execution is done; the result waits in its register while the next
// item is read. Slots at or above the high-water mark read as never used (generation 0,
// not live), so no clearing pass is needed after reset. A freed slot carries its bumped
// generation on the free stack, so an insert needs no slot-store read.
module generational_handle_table
   import ght_pkg::*;
#(
   parameter int SLOT_COUNT = 1024,
   parameter int GEN_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [SLOT_IN_W-1:0]  req_slot_index,
   input  logic [PORT_GEN_W-1:0] req_handle_generation,
   input  logic [KIND_W-1:0]     req_object_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output logic [SLOT_IN_W-1:0]  rsp_out_slot,
   output logic [PORT_GEN_W-1:0] rsp_out_generation,
   output logic [SLOT_IN_W-1:0]  rsp_live_total
);

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W   = (CNT_W > SLOT_IN_W) ? CNT_W : SLOT_IN_W;
   localparam int ENTRY_W = 1 + KIND_W + GEN_BITS;
   localparam int STACK_W = IDX_W + GEN_BITS;

   state_type             state_ff, state_in;
   logic [1:0]            cmd_ff;
   logic [CMP_W-1:0]      idx_ff;
   logic [PORT_GEN_W-1:0] gen_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [CNT_W-1:0]      next_unused_ff, next_unused_in;
   logic [IDX_W-1:0]      live_ff, live_in;

   logic [ENTRY_W-1:0]    slot_mem [SLOT_COUNT];
   logic [ENTRY_W-1:0]    rd_entry_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff;
   logic [SLOT_IN_W-1:0]  rsp_slot_ff;
   logic [PORT_GEN_W-1:0] rsp_gen_ff;
   logic [SLOT_IN_W-1:0]  rsp_live_ff;

   logic                  req_accept;
   logic                  exec_go;
   logic [CMP_W-1:0]      req_idx_ext;

   logic                  rd_live;
   logic [KIND_W-1:0]     rd_kind;
   logic [GEN_BITS-1:0]   rd_gen;
   logic [GEN_BITS-1:0]   bumped_gen;
   logic                  idx_known;
   logic                  handle_ok;

   stack_ctrl_type        stack_ctrl, stack_ctrl_raw;
   logic [STACK_W-1:0]    stack_push_data;
   logic [STACK_W-1:0]    stack_top;
   logic [CNT_W-1:0]      stack_depth;
   logic [IDX_W-1:0]      top_slot;
   logic [GEN_BITS-1:0]   top_gen;
   logic                  have_free;
   logic                  have_fresh;

   logic                  ok_sel;
   logic [IDX_W-1:0]      slot_sel;
   logic [GEN_BITS-1:0]   gen_sel;
   logic                  slot_we_raw;
   logic [IDX_W-1:0]      slot_waddr;
   logic [ENTRY_W-1:0]    slot_wdata;
   logic [CMP_W-1:0]      slot_ext;
   logic [CMP_W-1:0]      live_ext;

   assign req_accept  = req_valid && (state_ff == ST_IDLE);
   assign req_ready   = (state_ff == ST_IDLE);
   assign exec_go     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_idx_ext = CMP_W'(req_slot_index);

   // sequencer
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = req_accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = exec_go ? ST_IDLE : ST_EXEC;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_unused_ff <= CNT_W'(1);
         live_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_unused_ff <= next_unused_in;
         live_ff        <= live_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_command;
         idx_ff  <= req_idx_ext;
         gen_ff  <= req_handle_generation;
         kind_ff <= req_object_kind;
      end
   end

   // slot store: {live, kind, generation}
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_entry_ff <= slot_mem[req_idx_ext[IDX_W-1:0]];
      end
      if (exec_go && slot_we_raw) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
   end

   ght_free_stack #(
      .DEPTH  (SLOT_COUNT),
      .DATA_W (STACK_W)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .ctrl      (stack_ctrl),
      .push_data (stack_push_data),
      .top_data  (stack_top),
      .depth     (stack_depth)
   );

   assign stack_ctrl = exec_go ? stack_ctrl_raw : '0;
   assign top_slot   = stack_top[STACK_W-1:GEN_BITS];
   assign top_gen    = stack_top[GEN_BITS-1:0];
   assign have_free  = (stack_depth != '0);
   assign have_fresh = (next_unused_ff < CNT_W'(SLOT_COUNT));

   // handle lookup; slots at or above the high-water mark read as never used
   assign rd_live    = rd_entry_ff[ENTRY_W-1];
   assign rd_kind    = rd_entry_ff[GEN_BITS +: KIND_W];
   assign rd_gen     = rd_entry_ff[GEN_BITS-1:0];
   assign idx_known  = (idx_ff != '0) && (idx_ff < CMP_W'(next_unused_ff));
   assign handle_ok  = idx_known && rd_live && (PORT_GEN_W'(rd_gen) == gen_ff);
   assign bumped_gen = ((rd_gen + GEN_BITS'(1)) == '0) ? GEN_BITS'(1)
                                                       : rd_gen + GEN_BITS'(1);

   // command execution
   always_comb begin
      ok_sel          = 1'b0;
      slot_sel        = '0;
      gen_sel         = '0;
      next_unused_in  = next_unused_ff;
      live_in         = live_ff;
      slot_we_raw     = 1'b0;
      slot_waddr      = idx_ff[IDX_W-1:0];
      slot_wdata      = {1'b1, kind_ff, top_gen};
      stack_ctrl_raw  = '0;
      stack_push_data = {idx_ff[IDX_W-1:0], bumped_gen};
      case (cmd_ff)
         CMD_INSERT: begin
            if (have_free) begin
               slot_sel           = top_slot;
               gen_sel            = top_gen;
               stack_ctrl_raw.pop = 1'b1;
            end else if (have_fresh) begin
               slot_sel       = next_unused_ff[IDX_W-1:0];
               gen_sel        = GEN_BITS'(1);
               next_unused_in = next_unused_ff + CNT_W'(1);
            end
            if (have_free || have_fresh) begin
               ok_sel      = 1'b1;
               slot_we_raw = 1'b1;
               slot_waddr  = slot_sel;
               slot_wdata  = {1'b1, kind_ff, gen_sel};
               live_in     = live_ff + IDX_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (handle_ok) begin
               ok_sel              = 1'b1;
               slot_we_raw         = 1'b1;
               slot_wdata          = {1'b0, rd_kind, bumped_gen};
               stack_ctrl_raw.push = 1'b1;
               live_in             = live_ff - IDX_W'(1);
            end
         end
         CMD_CHECK: begin
            ok_sel = handle_ok && ((kind_ff == '0) || (rd_kind == kind_ff));
         end
         default: begin
            ok_sel = 1'b0;
         end
      endcase
      if (!exec_go) begin
         next_unused_in = next_unused_ff;
         live_in        = live_ff;
      end
   end

   // result register
   assign slot_ext     = CMP_W'(slot_sel);
   assign live_ext     = CMP_W'(live_in);
   assign rsp_valid_in = exec_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_ok_ff   <= ok_sel;
         rsp_slot_ff <= slot_ext[SLOT_IN_W-1:0];
         rsp_gen_ff  <= PORT_GEN_W'(gen_sel);
         rsp_live_ff <= live_ext[SLOT_IN_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_out_slot       = rsp_slot_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_live_total     = rsp_live_ff;

   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(stack_depth) + CNT_W'(live_ff)) == (next_unused_ff - CNT_W'(1)))
      else $error("free plus live slots differ from slots handed out");

   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      (next_unused_ff != '0) && (next_unused_ff <= CNT_W'(SLOT_COUNT)))
      else $error("high-water mark out of range");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside the execute cycle");

endmodule

// ----- tb/sv/ght_tb_pkg.sv -----
// Scoreboard for the generational handle table: predicts each result from the
// accepted items and checks the results in order. Depends on ght_pkg.
package ght_tb_pkg;
   import ght_pkg::*;

   localparam int TABLE_SLOTS = 1024;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0] KIND_ANY = '0;
   localparam logic [SLOT_IN_W-1:0] RESERVED_SLOT = '0;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_IN_W-1:0]  slot;
      logic [PORT_GEN_W-1:0] generation;
      logic [SLOT_IN_W-1:0]  live_total;
   } handle_result_type;

   class handle_table_scoreboard;
      logic [PORT_GEN_W-1:0] slot_gen [TABLE_SLOTS];
      bit                    slot_live [TABLE_SLOTS];
      logic [KIND_W-1:0]     slot_kind [TABLE_SLOTS];
      logic [SLOT_IN_W-1:0]  free_slots [TABLE_SLOTS];
      int                    free_depth;
      int                    next_unused;
      int                    live_slots;
      handle_result_type     pending [$];
      int                    errors;

      function new();
         foreach (slot_gen[i]) begin
            slot_gen[i]   = '0;
            slot_live[i]  = 1'b0;
            slot_kind[i]  = '0;
            free_slots[i] = '0;
         end
         free_depth  = 0;
         next_unused = 1;
         live_slots  = 0;
         errors      = 0;
      endfunction

      // slot in range, not reserved, same generation and live
      function bit handle_live(logic [SLOT_IN_W-1:0] s, logic [PORT_GEN_W-1:0] g);
         return s != RESERVED_SLOT && int'(s) < TABLE_SLOTS && slot_gen[s] == g
            && slot_live[s];
      endfunction

      // update the table for one accepted item and queue its result
      function void note_request(logic [1:0] cmd, logic [SLOT_IN_W-1:0] s,
                                 logic [PORT_GEN_W-1:0] g, logic [KIND_W-1:0] k);
         handle_result_type     r;
         logic [SLOT_IN_W-1:0]  pick;
         logic [PORT_GEN_W-1:0] bumped;
         bit                    have;
         r    = '0;
         pick = '0;
         have = 1'b0;
         case (cmd)
            CMD_INSERT: begin
               // freed slots first, then the high-water mark
               if (free_depth > 0) begin
                  free_depth--;
                  pick = free_slots[free_depth];
                  have = 1'b1;
               end else if (next_unused < TABLE_SLOTS) begin
                  pick = next_unused[SLOT_IN_W-1:0];
                  next_unused++;
                  have = 1'b1;
               end
               if (have && pick != RESERVED_SLOT) begin
                  if (slot_gen[pick] == '0) slot_gen[pick] = PORT_GEN_W'(1);
                  slot_kind[pick] = k;
                  if (!slot_live[pick]) begin
                     slot_live[pick] = 1'b1;
                     live_slots++;
                  end
                  r.ok         = 1'b1;
                  r.slot       = pick;
                  r.generation = slot_gen[pick];
               end
            end
            CMD_REMOVE: if (handle_live(s, g)) begin
               // bump the generation, never landing on zero
               bumped = slot_gen[s] + 1'b1;
               if (bumped == '0) bumped = PORT_GEN_W'(1);
               slot_gen[s]  = bumped;
               slot_live[s] = 1'b0;
               if (live_slots > 0) live_slots--;
               if (free_depth < TABLE_SLOTS) begin
                  free_slots[free_depth] = s;
                  free_depth++;
               end
               r.ok = 1'b1;
            end
            CMD_CHECK: begin
               if (handle_live(s, g) && (k == KIND_ANY || slot_kind[s] == k)) r.ok = 1'b1;
            end
            default: ;
         endcase
         r.live_total = live_slots[SLOT_IN_W-1:0];
         pending = {pending, r};
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // compare one result with the oldest prediction
      task check_response(logic ok, logic [SLOT_IN_W-1:0] s, logic [PORT_GEN_W-1:0] g,
                          logic [SLOT_IN_W-1:0] live);
         handle_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result ok=%0b slot=%0d gen=%0d live=%0d",
                             ok, s, g, live));
            return;
         end
         want = pending.pop_front();
         if (ok !== want.ok)
            report($sformatf("ok got %0b want %0b", ok, want.ok));
         if (s !== want.slot)
            report($sformatf("out_slot got %0d want %0d", s, want.slot));
         if (g !== want.generation)
            report($sformatf("out_generation got %0d want %0d", g, want.generation));
         if (live !== want.live_total)
            report($sformatf("live_total got %0d want %0d", live, want.live_total));
      endtask
   endclass

endpackage

// ----- tb/sv/tb.sv -----
// Top-level testbench for generational_handle_table: directed and random items
// with random idling on both sides. Depends on ght_pkg and ght_tb_pkg.
module tb;
   import ght_pkg::*;
   import ght_tb_pkg::*;

   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 150;
   localparam int FULL_LIVE   = TABLE_SLOTS - 1;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic [1:0]            req_command = CMD_INSERT;
   logic [SLOT_IN_W-1:0]  req_slot_index = '0;
   logic [PORT_GEN_W-1:0] req_handle_generation = '0;
   logic [KIND_W-1:0]     req_object_kind = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic                  rsp_ok;
   logic [SLOT_IN_W-1:0]  rsp_out_slot;
   logic [PORT_GEN_W-1:0] rsp_out_generation;
   logic [SLOT_IN_W-1:0]  rsp_live_total;

   // long receiver hold-off requests, sender to receiver
   int hold_asks = 0;
   int hold_seen = 0;
   int quiet_items = 0;
   bit send_steady = 0;

   handle_table_scoreboard sb = new();

   generational_handle_table #(
      .SLOT_COUNT(TABLE_SLOTS),
      .GEN_BITS  (PORT_GEN_W)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_slot_index       (req_slot_index),
      .req_handle_generation(req_handle_generation),
      .req_object_kind      (req_object_kind),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ok               (rsp_ok),
      .rsp_out_slot         (rsp_out_slot),
      .rsp_out_generation   (rsp_out_generation),
      .rsp_live_total       (rsp_live_total)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // sender gap: mostly none or short, a few long
   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(99));
      if (send_steady || quiet_items > 0) return 0;
      if (roll < 55) return 0;
      if (roll < 85) return int'($urandom_range(2, 1));
      if (roll < 96) return int'($urandom_range(8, 3));
      return int'($urandom_range(40, 15));
   endfunction

   // offer one item, wait for it to be taken, then maybe idle
   task automatic send_item(logic [1:0] cmd, logic [SLOT_IN_W-1:0] s,
                            logic [PORT_GEN_W-1:0] g, logic [KIND_W-1:0] k);
      int gap;
      req_valid             <= 1'b1;
      req_command           <= cmd;
      req_slot_index        <= s;
      req_handle_generation <= g;
      req_object_kind       <= k;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, s, g, k);
      if (quiet_items > 0) quiet_items--;
      if ($urandom_range(49) == 0) send_steady = !send_steady;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   // mostly a live handle, else a stale, dead or random one
   task automatic pick_target(output logic [SLOT_IN_W-1:0] s,
                              output logic [PORT_GEN_W-1:0] g);
      int roll;
      int top;
      int tries;
      top  = (sb.next_unused > 1) ? sb.next_unused - 1 : 1;
      roll = int'($urandom_range(99));
      s    = SLOT_IN_W'($urandom_range(top, 1));
      if (roll < 75) begin
         for (tries = 0; tries < 16 && !sb.slot_live[s]; tries++)
            s = SLOT_IN_W'($urandom_range(top, 1));
         g = sb.slot_gen[s];
      end else if (roll < 88) begin
         g = sb.slot_gen[s] - 1'b1;
      end else if (roll < 96) begin
         g = sb.slot_gen[s];
      end else begin
         s = SLOT_IN_W'($urandom);
         g = PORT_GEN_W'($urandom);
      end
   endtask

   // one random item; the rest above the three shares is noise
   task automatic send_random(int insert_pct, int remove_pct, int check_pct);
      logic [1:0]            cmd;
      logic [SLOT_IN_W-1:0]  s;
      logic [PORT_GEN_W-1:0] g;
      logic [KIND_W-1:0]     k;
      int                    roll;
      roll = int'($urandom_range(99));
      s    = SLOT_IN_W'($urandom);
      g    = PORT_GEN_W'($urandom);
      k    = KIND_W'($urandom_range(7));
      if (roll < insert_pct) begin
         cmd = CMD_INSERT;
      end else if (roll < insert_pct + remove_pct) begin
         cmd = CMD_REMOVE;
         pick_target(s, g);
      end else if (roll < insert_pct + remove_pct + check_pct) begin
         cmd = CMD_CHECK;
         pick_target(s, g);
         case ($urandom_range(2))
            0: k = KIND_ANY;
            1: k = sb.slot_kind[s];
            default: ;
         endcase
      end else begin
         cmd = 2'($urandom_range(3));
      end
      send_item(cmd, s, g, k);
   endtask

   // receiver: check results, stall at random, one long hold on request
   initial begin : receiver
      int stall_left;
      int roll;
      bit steady;
      stall_left = 0;
      steady     = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_ok, rsp_out_slot, rsp_out_generation, rsp_live_total);
         if ($urandom_range(99) == 0) steady = !steady;
         if (hold_seen != hold_asks) begin
            hold_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            roll = int'($urandom_range(99));
            if (roll < 65) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready  <= 1'b0;
               stall_left = (roll < 92) ? int'($urandom_range(2))
                                        : int'($urandom_range(30, 5));
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("** generational_handle_table: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;

      // reserved slot and never-used slots
      send_item(CMD_CHECK, RESERVED_SLOT, '0, KIND_ANY);
      send_item(CMD_REMOVE, RESERVED_SLOT, '0, KIND_ANY);
      send_item(CMD_CHECK, 10'd1, '0, KIND_ANY);
      // first inserts come from the high-water mark
      send_item(CMD_INSERT, '0, '0, 3'd7);
      send_item(CMD_INSERT, '0, '0, KIND_ANY);
      // any kind, kind match, wrong kind, wide generation
      send_item(CMD_CHECK, 10'd1, 32'd1, KIND_ANY);
      send_item(CMD_CHECK, 10'd1, 32'd1, 3'd7);
      send_item(CMD_CHECK, 10'd1, 32'd1, 3'd3);
      send_item(CMD_CHECK, 10'd1, '1, KIND_ANY);
      // stale remove, good remove, duplicate remove, stale check
      send_item(CMD_REMOVE, 10'd1, 32'd2, KIND_ANY);
      send_item(CMD_REMOVE, 10'd1, 32'd1, KIND_ANY);
      send_item(CMD_REMOVE, 10'd1, 32'd1, KIND_ANY);
      send_item(CMD_CHECK, 10'd1, 32'd1, KIND_ANY);
      // insert reuses the freed slot and ignores the handle fields
      send_item(CMD_INSERT, '1, '1, 3'd5);
      send_item(CMD_CHECK, 10'd1, 32'd2, 3'd5);
      // unknown command with every bit set
      send_item(CMD_UNUSED, '1, '1, '1);
      // remove ignores the kind
      send_item(CMD_REMOVE, 10'd2, 32'd1, 3'd7);
      send_item(CMD_INSERT, '0, '0, 3'd2);
      send_item(CMD_CHECK, '1, '0, KIND_ANY);
      send_item(CMD_REMOVE, '1, '1, '1);
      send_item(CMD_CHECK, 10'd2, 32'd2, 3'd2);

      // mixed traffic, with a long receiver hold and a full drain
      for (n = 0; n < 250; n++) begin
         if (n == 60) begin
            hold_asks   <= hold_asks + 1;
            quiet_items = 80;
         end
         if (n == 180) drain_results();
         send_random(40, 20, 25);
      end

      // fill the table, then keep inserting into a full table
      for (n = 0; n < 3000 && sb.live_slots < FULL_LIVE; n++) send_random(90, 3, 5);
      repeat (30) send_random(90, 3, 5);

      // mostly removes, with some inserts refilling from the free stack
      repeat (300) send_random(10, 60, 20);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("** generational_handle_table: PASSED **");
      end else begin
         $display("** generational_handle_table: FAILED **");
      end
      $finish;
   end

endmodule
